@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge of clk, held off during reset
`define ADAFSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain check on every rising edge of clk, also during reset
`define ADAFSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/adafsm_pkg.sv @@
// types and constants of the airlock door access controller
package adafsm_pkg;

  // controller phases
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_OUTER_OPEN  = 4'd1;
  localparam logic [3:0] PH_PIN         = 4'd2;
  localparam logic [3:0] PH_INNER_OPEN  = 4'd3;
  localparam logic [3:0] PH_WAIT_EXIT   = 4'd4;
  localparam logic [3:0] PH_EXIT_Q      = 4'd5;
  localparam logic [3:0] PH_OPEN_BOTH   = 4'd6;
  localparam logic [3:0] PH_BOTH_OPEN   = 4'd7;
  localparam logic [3:0] PH_ALARM       = 4'd8;
  localparam logic [3:0] PH_ALARM_HOLD  = 4'd9;
  localparam logic [3:0] PH_RESET_Q     = 4'd10;

  // message codes
  localparam logic [3:0] MSG_NONE         = 4'd0;
  localparam logic [3:0] MSG_GREETING     = 4'd1;
  localparam logic [3:0] MSG_OPEN_OUTER   = 4'd2;
  localparam logic [3:0] MSG_CLOSE_OUTER  = 4'd3;
  localparam logic [3:0] MSG_PIN_REQUEST  = 4'd4;
  localparam logic [3:0] MSG_OPEN_INNER   = 4'd5;
  localparam logic [3:0] MSG_PIN_REJECTED = 4'd6;
  localparam logic [3:0] MSG_CLOSE_INNER  = 4'd7;
  localparam logic [3:0] MSG_EXIT_Q       = 4'd8;
  localparam logic [3:0] MSG_OPEN_ALL     = 4'd9;
  localparam logic [3:0] MSG_CLOSE_ALL    = 4'd10;
  localparam logic [3:0] MSG_INTRUDER     = 4'd11;
  localparam logic [3:0] MSG_RESET_Q      = 4'd12;

  // sound commands
  localparam logic [2:0] SND_KEEP     = 3'd0;
  localparam logic [2:0] SND_STOP     = 3'd1;
  localparam logic [2:0] SND_ACUTE    = 3'd2;
  localparam logic [2:0] SND_PRESSURE = 3'd3;
  localparam logic [2:0] SND_ALARM    = 3'd4;

  // intensity commands
  localparam logic [1:0] INT_KEEP  = 2'd0;
  localparam logic [1:0] INT_START = 2'd1;
  localparam logic [1:0] INT_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_DOOR_TICKS   = 3'd0;
  localparam logic [2:0] CFG_PIN_TIMEOUT  = 3'd1;
  localparam logic [2:0] CFG_ALARM_HOLD   = 3'd2;
  localparam logic [2:0] CFG_MAX_ATTEMPTS = 3'd3;
  localparam logic [2:0] CFG_EXPECTED_PIN = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 56;

  // configuration reset values
  localparam logic [15:0] DOOR_TICKS_RST   = 16'd1000;
  localparam logic [15:0] PIN_TIMEOUT_RST  = 16'd60000;
  localparam logic [15:0] ALARM_HOLD_RST   = 16'd5000;
  localparam logic [2:0]  MAX_ATTEMPTS_RST = 3'd3;
  localparam logic [55:0] EXPECTED_PIN_RST = 56'h31363132474552; // "1612GER"

  // operator replies
  localparam logic [23:0] REPLY_YES = 24'h596573; // "Yes"
  localparam logic [15:0] REPLY_NO  = 16'h4E6F;   // "No"

  localparam logic [15:0] TICKS_MAX    = 16'hFFFF;
  localparam logic [2:0]  ATTEMPTS_MAX = 3'd7;

endpackage

@@ hw/rtl/adafsm_if.sv @@
// valid/ready channel interfaces for polls and results
interface adafsm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  tick_count;
  logic        hall_pulse;
  logic        exit_pulse;
  logic        serial_busy;
  logic        pin_ready;
  logic [55:0] pin_text;
  logic        reply_ready;
  logic [23:0] reply_text;

  modport source (
    output valid, tick_count, hall_pulse, exit_pulse, serial_busy,
           pin_ready, pin_text, reply_ready, reply_text,
    input  ready
  );
  modport sink (
    input  valid, tick_count, hall_pulse, exit_pulse, serial_busy,
           pin_ready, pin_text, reply_ready, reply_text,
    output ready
  );
endinterface

interface adafsm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] message;
  logic       start_pin_entry;
  logic       start_reply_capture;
  logic [2:0] sound_command;
  logic [1:0] intensity_command;
  logic       ok_lamp;
  logic       alarm_lamp;
  logic [3:0] phase_now;

  modport source (
    output valid, message, start_pin_entry, start_reply_capture, sound_command,
           intensity_command, ok_lamp, alarm_lamp, phase_now,
    input  ready
  );
  modport sink (
    input  valid, message, start_pin_entry, start_reply_capture, sound_command,
           intensity_command, ok_lamp, alarm_lamp, phase_now,
    output ready
  );
endinterface

@@ hw/rtl/airlock_door_access_fsm.sv @@
// airlock door access controller: poll register, phase logic, result register
// a poll is taken into the poll register, then its result is loaded into the result
// register, from which the result transaction is made
// throughput: one poll per cycle while results are taken, set by the phase update
// a stalled result holds back the poll register only once that register is full
// reset: synchronous active-low rst_n clears both stages, restores the phase
// state (hello pending, ok lamp on) and the configuration registers to defaults
`include "assert_macros.svh"

module airlock_door_access_fsm (
  input  logic                                 clk,
  input  logic                                 rst_n,
  adafsm_in_if.sink                            in_ch,
  adafsm_out_if.source                         out_ch,
  input  logic                                 cfg_we,
  input  logic [adafsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [adafsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import adafsm_pkg::*;

  // configuration registers
  logic [15:0] door_ticks_r;
  logic [15:0] pin_timeout_r;
  logic [15:0] alarm_hold_r;
  logic [2:0]  max_attempts_r;
  logic [55:0] expected_pin_r;

  // poll register (first stage)
  logic        s1_valid_r;
  logic [3:0]  s1_ticks_r;
  logic        s1_hall_r;
  logic        s1_exit_r;
  logic        s1_busy_r;
  logic        s1_pin_ready_r;
  logic [55:0] s1_pin_r;
  logic        s1_reply_ready_r;
  logic [23:0] s1_reply_r;

  // controller state
  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [2:0]  wrong_r, wrong_nxt;
  logic        hello_pend_r, hello_pend_nxt;
  logic        hall_lat_r, hall_lat_nxt;
  logic        exit_lat_r, exit_lat_nxt;
  logic        ask_pin_r, ask_pin_nxt;
  logic        prompt_r, prompt_nxt;
  logic        capture_r, capture_nxt;
  logic        ok_led_r, ok_led_nxt;
  logic        alarm_led_r, alarm_led_nxt;

  // result register (second stage)
  logic        out_valid_r;
  logic [3:0]  out_msg_r, msg_nxt;
  logic        out_start_pin_r, start_pin_nxt;
  logic        out_start_cap_r, start_cap_nxt;
  logic [2:0]  out_snd_r, snd_nxt;
  logic [1:0]  out_int_r, int_nxt;

  logic        advance;
  logic [16:0] tick_sum;
  logic        busy;

  // the poll moves into the result register when that register is empty or drained
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_ticks_r   <= DOOR_TICKS_RST;
      pin_timeout_r  <= PIN_TIMEOUT_RST;
      alarm_hold_r   <= ALARM_HOLD_RST;
      max_attempts_r <= MAX_ATTEMPTS_RST;
      expected_pin_r <= EXPECTED_PIN_RST;
    end else if (cfg_we) begin
      // indexes past the register list are ignored
      unique case (cfg_index)
        CFG_DOOR_TICKS:   door_ticks_r   <= cfg_data[15:0];
        CFG_PIN_TIMEOUT:  pin_timeout_r  <= cfg_data[15:0];
        CFG_ALARM_HOLD:   alarm_hold_r   <= cfg_data[15:0];
        CFG_MAX_ATTEMPTS: max_attempts_r <= cfg_data[2:0];
        CFG_EXPECTED_PIN: expected_pin_r <= cfg_data[55:0];
        default: ;
      endcase
    end
  end

  // ---------------- poll register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_ticks_r       <= in_ch.tick_count;
      s1_hall_r        <= in_ch.hall_pulse;
      s1_exit_r        <= in_ch.exit_pulse;
      s1_busy_r        <= in_ch.serial_busy;
      s1_pin_ready_r   <= in_ch.pin_ready;
      s1_pin_r         <= in_ch.pin_text;
      s1_reply_ready_r <= in_ch.reply_ready;
      s1_reply_r       <= in_ch.reply_text;
    end
  end

  // ---------------- phase logic ----------------
  always_comb begin
    // saturating tick counter and pulse latches come first in every poll
    tick_sum    = {1'b0, elapsed_r} + {13'd0, s1_ticks_r};
    elapsed_nxt = tick_sum[16] ? TICKS_MAX : tick_sum[15:0];
    hall_lat_nxt   = hall_lat_r || s1_hall_r;
    exit_lat_nxt   = exit_lat_r || s1_exit_r;

    phase_nxt      = phase_r;
    wrong_nxt      = wrong_r;
    hello_pend_nxt = hello_pend_r;
    ask_pin_nxt    = ask_pin_r;
    prompt_nxt     = prompt_r;
    capture_nxt    = capture_r;
    ok_led_nxt     = ok_led_r;
    alarm_led_nxt  = alarm_led_r;

    msg_nxt       = MSG_NONE;
    snd_nxt       = SND_KEEP;
    int_nxt       = INT_KEEP;
    start_pin_nxt = 1'b0;
    start_cap_nxt = 1'b0;
    // a message sent in this poll occupies the serial link for the rest of it
    busy          = s1_busy_r;

    unique case (phase_r)
      PH_IDLE: begin
        if (hello_pend_r) begin
          if (!busy) begin
            msg_nxt        = MSG_GREETING;
            hello_pend_nxt = 1'b0;
          end
        end else if (hall_lat_nxt && !busy) begin
          msg_nxt      = MSG_OPEN_OUTER;
          snd_nxt      = SND_ACUTE;
          hall_lat_nxt = 1'b0;
          elapsed_nxt  = '0;
          phase_nxt    = PH_OUTER_OPEN;
        end
      end
      PH_OUTER_OPEN: begin
        // close outer goes out whether or not the link is busy
        if (elapsed_nxt >= door_ticks_r) begin
          msg_nxt     = MSG_CLOSE_OUTER;
          snd_nxt     = SND_PRESSURE;
          int_nxt     = INT_START;
          elapsed_nxt = '0;
          ask_pin_nxt = 1'b1;
          phase_nxt   = PH_PIN;
        end
      end
      PH_PIN: begin
        if (ask_pin_r && !busy) begin
          start_pin_nxt = 1'b1;
          msg_nxt       = MSG_PIN_REQUEST;
          ask_pin_nxt   = 1'b0;
          busy          = 1'b1;
        end
        if (elapsed_nxt >= pin_timeout_r || wrong_r >= max_attempts_r) begin
          phase_nxt = PH_ALARM;
        end else if (s1_pin_ready_r && !busy) begin
          if (s1_pin_r == expected_pin_r) begin
            msg_nxt     = MSG_OPEN_INNER;
            snd_nxt     = SND_ACUTE;
            int_nxt     = INT_STOP;
            elapsed_nxt = '0;
            phase_nxt   = PH_INNER_OPEN;
          end else begin
            if (wrong_r != ATTEMPTS_MAX) begin
              wrong_nxt = wrong_r + 3'd1;
            end
            msg_nxt     = MSG_PIN_REJECTED;
            ask_pin_nxt = 1'b1;
          end
        end
      end
      PH_INNER_OPEN: begin
        // the phase moves on even if the close message is dropped
        if (elapsed_nxt >= door_ticks_r) begin
          elapsed_nxt = '0;
          phase_nxt   = PH_WAIT_EXIT;
          if (!busy) begin
            msg_nxt = MSG_CLOSE_INNER;
          end
        end
      end
      PH_WAIT_EXIT: begin
        if (exit_lat_nxt) begin
          exit_lat_nxt = 1'b0;
          prompt_nxt   = 1'b1;
          capture_nxt  = 1'b0;
          phase_nxt    = PH_EXIT_Q;
        end
      end
      PH_EXIT_Q, PH_RESET_Q: begin
        if (prompt_nxt && !busy) begin
          msg_nxt     = (phase_r == PH_EXIT_Q) ? MSG_EXIT_Q : MSG_RESET_Q;
          prompt_nxt  = 1'b0;
          capture_nxt = 1'b1;
          busy        = 1'b1;
        end
        if (capture_nxt && !busy) begin
          start_cap_nxt = 1'b1;
          capture_nxt   = 1'b0;
        end
        if (s1_reply_ready_r) begin
          if (s1_reply_r == REPLY_YES) begin
            if (phase_r == PH_EXIT_Q) begin
              phase_nxt = PH_OPEN_BOTH;
            end else begin
              // controller restart
              phase_nxt      = PH_IDLE;
              elapsed_nxt    = '0;
              wrong_nxt      = '0;
              hello_pend_nxt = 1'b1;
              hall_lat_nxt   = 1'b0;
              exit_lat_nxt   = 1'b0;
              ask_pin_nxt    = 1'b0;
              prompt_nxt     = 1'b0;
              capture_nxt    = 1'b0;
              ok_led_nxt     = 1'b1;
              alarm_led_nxt  = 1'b0;
              snd_nxt        = SND_STOP;
              int_nxt        = INT_STOP;
            end
          end else if (phase_r == PH_EXIT_Q && s1_reply_r[23:8] == REPLY_NO) begin
            phase_nxt = PH_ALARM;
          end else begin
            // anything else asks again
            prompt_nxt = 1'b1;
          end
        end
      end
      PH_OPEN_BOTH: begin
        if (!busy) begin
          msg_nxt     = MSG_OPEN_ALL;
          snd_nxt     = SND_ACUTE;
          elapsed_nxt = '0;
          phase_nxt   = PH_BOTH_OPEN;
        end
      end
      PH_BOTH_OPEN: begin
        if (!busy && elapsed_nxt >= door_ticks_r) begin
          msg_nxt        = MSG_CLOSE_ALL;
          // controller restart
          phase_nxt      = PH_IDLE;
          elapsed_nxt    = '0;
          wrong_nxt      = '0;
          hello_pend_nxt = 1'b1;
          hall_lat_nxt   = 1'b0;
          exit_lat_nxt   = 1'b0;
          ask_pin_nxt    = 1'b0;
          prompt_nxt     = 1'b0;
          capture_nxt    = 1'b0;
          ok_led_nxt     = 1'b1;
          alarm_led_nxt  = 1'b0;
          snd_nxt        = SND_STOP;
          int_nxt        = INT_STOP;
        end
      end
      PH_ALARM: begin
        if (!busy) begin
          msg_nxt       = MSG_INTRUDER;
          alarm_led_nxt = 1'b1;
          ok_led_nxt    = 1'b0;
          int_nxt       = INT_STOP;
          snd_nxt       = SND_ALARM;
          elapsed_nxt   = '0;
          phase_nxt     = PH_ALARM_HOLD;
        end
      end
      PH_ALARM_HOLD: begin
        if (elapsed_nxt >= alarm_hold_r) begin
          elapsed_nxt = '0;
          prompt_nxt  = 1'b1;
          capture_nxt = 1'b0;
          phase_nxt   = PH_RESET_Q;
        end
      end
      default: begin
        // unused phase codes fall back to idle
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // ---------------- state update ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      elapsed_r    <= '0;
      wrong_r      <= '0;
      hello_pend_r <= 1'b1;
      hall_lat_r   <= 1'b0;
      exit_lat_r   <= 1'b0;
      ask_pin_r    <= 1'b0;
      prompt_r     <= 1'b0;
      capture_r    <= 1'b0;
      ok_led_r     <= 1'b1;
      alarm_led_r  <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      elapsed_r    <= elapsed_nxt;
      wrong_r      <= wrong_nxt;
      hello_pend_r <= hello_pend_nxt;
      hall_lat_r   <= hall_lat_nxt;
      exit_lat_r   <= exit_lat_nxt;
      ask_pin_r    <= ask_pin_nxt;
      prompt_r     <= prompt_nxt;
      capture_r    <= capture_nxt;
      ok_led_r     <= ok_led_nxt;
      alarm_led_r  <= alarm_led_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_msg_r       <= msg_nxt;
      out_start_pin_r <= start_pin_nxt;
      out_start_cap_r <= start_cap_nxt;
      out_snd_r       <= snd_nxt;
      out_int_r       <= int_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.message             = out_msg_r;
  assign out_ch.start_pin_entry     = out_start_pin_r;
  assign out_ch.start_reply_capture = out_start_cap_r;
  assign out_ch.sound_command       = out_snd_r;
  assign out_ch.intensity_command   = out_int_r;
  // lamps and phase are the state left behind by the transaction in the result register
  assign out_ch.ok_lamp             = ok_led_r;
  assign out_ch.alarm_lamp          = alarm_led_r;
  assign out_ch.phase_now           = phase_r;

  // ---------------- assertions ----------------
  `ADAFSM_ASSERT(a_lamps_exclusive, alarm_led_r |-> !ok_led_r, "ok and alarm lamps both on")
  `ADAFSM_ASSERT(a_phase_holds, !advance |=> $stable(phase_r), "phase moved without a poll")
  `ADAFSM_ASSERT(a_attempts_hold, !advance |=> $stable(wrong_r), "attempt count moved idle")
  `ADAFSM_ASSERT(a_poll_kept, (s1_valid_r && !advance) |=> s1_valid_r, "stalled poll dropped")

endmodule

@@ tb/airlock_door_access_fsm_tb.sv @@
// self-checking testbench for the airlock door access controller
module airlock_door_access_fsm_tb;
  import adafsm_pkg::*;

  // one poll as the controller sees it
  typedef struct packed {
    logic [3:0]  ticks;
    logic        hall;
    logic        exit_req;
    logic        busy;
    logic        pin_rdy;
    logic [55:0] pin;
    logic        reply_rdy;
    logic [23:0] reply;
  } airlock_poll_t;

  // what the controller answers for one poll
  typedef struct packed {
    logic [3:0] message;
    logic       start_pin;
    logic       start_cap;
    logic [2:0] sound;
    logic [1:0] intensity;
    logic       ok_lamp;
    logic       alarm_lamp;
    logic [3:0] phase;
  } airlock_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  adafsm_in_if  in_ch ();
  adafsm_out_if out_ch ();

  airlock_door_access_fsm uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 time unit clock period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // controller copy kept by the testbench: configuration registers
  logic [15:0] door_ticks_reg;
  logic [15:0] pin_timeout_reg;
  logic [15:0] alarm_hold_reg;
  logic [2:0]  max_attempts_reg;
  logic [55:0] expected_pin_reg;

  // controller copy: phase state, counters and pending flags
  logic [3:0]  ctl_phase;
  logic [15:0] ctl_elapsed;
  logic [2:0]  ctl_wrong;
  logic        ctl_hello_pend;
  logic        ctl_hall;
  logic        ctl_exit;
  logic        ctl_ask_pend;
  logic        ctl_prompt_pend;
  logic        ctl_capture_pend;
  logic        ctl_ok;
  logic        ctl_alarm;

  // responses predicted for accepted polls, oldest first
  airlock_result_t awaited_responses[$];
  int              mismatch_count;
  bit              idling_on;
  int              ready_stall_left;

  // restart after close both or a yes to the reset question, and after reset
  function automatic void restart_controller();
    ctl_phase        = PH_IDLE;
    ctl_elapsed      = '0;
    ctl_wrong        = '0;
    ctl_hello_pend   = 1'b1;
    ctl_hall         = 1'b0;
    ctl_exit         = 1'b0;
    ctl_ask_pend     = 1'b0;
    ctl_prompt_pend  = 1'b0;
    ctl_capture_pend = 1'b0;
    ctl_ok           = 1'b1;
    ctl_alarm        = 1'b0;
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DOOR_TICKS:   door_ticks_reg   = data[15:0];
      CFG_PIN_TIMEOUT:  pin_timeout_reg  = data[15:0];
      CFG_ALARM_HOLD:   alarm_hold_reg   = data[15:0];
      CFG_MAX_ATTEMPTS: max_attempts_reg = data[2:0];
      CFG_EXPECTED_PIN: expected_pin_reg = data[55:0];
      default: ;
    endcase
  endfunction

  // one poll through the controller: tick accumulation, latches, one decision
  function automatic airlock_result_t advance_controller(input airlock_poll_t p);
    airlock_result_t r;
    logic [16:0]     sum;
    logic            busy;
    r    = '0;
    busy = p.busy;
    sum  = {1'b0, ctl_elapsed} + 17'(p.ticks);
    ctl_elapsed = sum[16] ? TICKS_MAX : sum[15:0];
    if (p.hall) ctl_hall = 1'b1;
    if (p.exit_req) ctl_exit = 1'b1;

    case (ctl_phase)
      PH_IDLE: begin
        if (ctl_hello_pend) begin
          if (!busy) begin
            r.message      = MSG_GREETING;
            ctl_hello_pend = 1'b0;
          end
        end else if (ctl_hall && !busy) begin
          r.message   = MSG_OPEN_OUTER;
          r.sound     = SND_ACUTE;
          ctl_hall    = 1'b0;
          ctl_elapsed = '0;
          ctl_phase   = PH_OUTER_OPEN;
        end
      end
      PH_OUTER_OPEN: begin
        // close outer goes out whether or not the serial link is busy
        if (ctl_elapsed >= door_ticks_reg) begin
          r.message    = MSG_CLOSE_OUTER;
          r.sound      = SND_PRESSURE;
          r.intensity  = INT_START;
          ctl_elapsed  = '0;
          ctl_ask_pend = 1'b1;
          ctl_phase    = PH_PIN;
        end
      end
      PH_PIN: begin
        if (ctl_ask_pend && !busy) begin
          r.start_pin  = 1'b1;
          r.message    = MSG_PIN_REQUEST;
          ctl_ask_pend = 1'b0;
          busy         = 1'b1;
        end
        if (ctl_elapsed >= pin_timeout_reg || ctl_wrong >= max_attempts_reg) begin
          ctl_phase = PH_ALARM;
        end else if (p.pin_rdy && !busy) begin
          if (p.pin == expected_pin_reg) begin
            r.message   = MSG_OPEN_INNER;
            r.sound     = SND_ACUTE;
            r.intensity = INT_STOP;
            ctl_elapsed = '0;
            ctl_phase   = PH_INNER_OPEN;
          end else begin
            if (ctl_wrong < ATTEMPTS_MAX) ctl_wrong = ctl_wrong + 3'd1;
            r.message    = MSG_PIN_REJECTED;
            ctl_ask_pend = 1'b1;
          end
        end
      end
      PH_INNER_OPEN: begin
        if (ctl_elapsed >= door_ticks_reg) begin
          ctl_elapsed = '0;
          ctl_phase   = PH_WAIT_EXIT;
          if (!busy) r.message = MSG_CLOSE_INNER;
        end
      end
      PH_WAIT_EXIT: begin
        if (ctl_exit) begin
          ctl_exit         = 1'b0;
          ctl_prompt_pend  = 1'b1;
          ctl_capture_pend = 1'b0;
          ctl_phase        = PH_EXIT_Q;
        end
      end
      PH_EXIT_Q, PH_RESET_Q: begin
        if (ctl_prompt_pend && !busy) begin
          r.message        = (ctl_phase == PH_EXIT_Q) ? MSG_EXIT_Q : MSG_RESET_Q;
          ctl_prompt_pend  = 1'b0;
          ctl_capture_pend = 1'b1;
          busy             = 1'b1;
        end
        if (ctl_capture_pend && !busy) begin
          r.start_cap      = 1'b1;
          ctl_capture_pend = 1'b0;
        end
        if (p.reply_rdy) begin
          // yes needs all three characters, no only the first two
          if (p.reply == REPLY_YES) begin
            if (ctl_phase == PH_EXIT_Q) begin
              ctl_phase = PH_OPEN_BOTH;
            end else begin
              restart_controller();
              r.sound     = SND_STOP;
              r.intensity = INT_STOP;
            end
          end else if (ctl_phase == PH_EXIT_Q && p.reply[23:8] == REPLY_NO) begin
            ctl_phase = PH_ALARM;
          end else begin
            ctl_prompt_pend = 1'b1;
          end
        end
      end
      PH_OPEN_BOTH: begin
        if (!busy) begin
          r.message   = MSG_OPEN_ALL;
          r.sound     = SND_ACUTE;
          ctl_elapsed = '0;
          ctl_phase   = PH_BOTH_OPEN;
        end
      end
      PH_BOTH_OPEN: begin
        if (!busy && ctl_elapsed >= door_ticks_reg) begin
          r.message = MSG_CLOSE_ALL;
          restart_controller();
          r.sound     = SND_STOP;
          r.intensity = INT_STOP;
        end
      end
      PH_ALARM: begin
        if (!busy) begin
          r.message   = MSG_INTRUDER;
          ctl_alarm   = 1'b1;
          ctl_ok      = 1'b0;
          r.intensity = INT_STOP;
          r.sound     = SND_ALARM;
          ctl_elapsed = '0;
          ctl_phase   = PH_ALARM_HOLD;
        end
      end
      PH_ALARM_HOLD: begin
        if (ctl_elapsed >= alarm_hold_reg) begin
          ctl_elapsed      = '0;
          ctl_prompt_pend  = 1'b1;
          ctl_capture_pend = 1'b0;
          ctl_phase        = PH_RESET_Q;
        end
      end
      default: ctl_phase = PH_IDLE;
    endcase

    r.ok_lamp    = ctl_ok;
    r.alarm_lamp = ctl_alarm;
    r.phase      = ctl_phase;
    return r;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // input transactions feed the predictor, result transactions are checked
  // against the oldest prediction; both sampled at the rising edge
  always @(posedge clk) begin : monitor
    airlock_poll_t   seen;
    airlock_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.ticks     = in_ch.tick_count;
        seen.hall      = in_ch.hall_pulse;
        seen.exit_req  = in_ch.exit_pulse;
        seen.busy      = in_ch.serial_busy;
        seen.pin_rdy   = in_ch.pin_ready;
        seen.pin       = in_ch.pin_text;
        seen.reply_rdy = in_ch.reply_ready;
        seen.reply     = in_ch.reply_text;
        awaited_responses.push_back(advance_controller(seen));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch("result transaction with no poll outstanding");
        end else begin
          want = awaited_responses.pop_front();
          check_field("message", out_ch.message, want.message);
          check_field("start_pin_entry", out_ch.start_pin_entry, want.start_pin);
          check_field("start_reply_capture", out_ch.start_reply_capture, want.start_cap);
          check_field("sound_command", out_ch.sound_command, want.sound);
          check_field("intensity_command", out_ch.intensity_command, want.intensity);
          check_field("ok_lamp", out_ch.ok_lamp, want.ok_lamp);
          check_field("alarm_lamp", out_ch.alarm_lamp, want.alarm_lamp);
          check_field("phase_now", out_ch.phase_now, want.phase);
        end
      end
    end
  end

  // result side back-pressure: random stall bursts while idling is on
  always @(negedge clk) begin
    if (ready_stall_left > 0) begin
      ready_stall_left--;
      out_ch.ready = 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      ready_stall_left = $urandom_range(0, 8);
      out_ch.ready     = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // one poll transaction; entered and left at a falling edge, valid left high
  // so back-to-back polls follow without a gap
  task automatic send_poll(input airlock_poll_t p);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.tick_count  = p.ticks;
    in_ch.hall_pulse  = p.hall;
    in_ch.exit_pulse  = p.exit_req;
    in_ch.serial_busy = p.busy;
    in_ch.pin_ready   = p.pin_rdy;
    in_ch.pin_text    = p.pin;
    in_ch.reply_ready = p.reply_rdy;
    in_ch.reply_text  = p.reply;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic airlock_poll_t mk_poll(input logic [3:0] t, input logic hall,
      input logic exit_req, input logic busy, input logic pin_rdy,
      input logic [55:0] pin, input logic reply_rdy, input logic [23:0] reply);
    airlock_poll_t p;
    p.ticks     = t;
    p.hall      = hall;
    p.exit_req  = exit_req;
    p.busy      = busy;
    p.pin_rdy   = pin_rdy;
    p.pin       = pin;
    p.reply_rdy = reply_rdy;
    p.reply     = reply;
    return p;
  endfunction

  task automatic quiet(input logic [3:0] t);
    send_poll(mk_poll(t, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
  endtask

  task automatic send_pin(input logic busy, input logic [55:0] pin);
    send_poll(mk_poll(4'd0, 1'b0, 1'b0, busy, 1'b1, pin, 1'b0, '0));
  endtask

  task automatic send_reply(input logic [23:0] reply);
    send_poll(mk_poll(4'd0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1, reply));
  endtask

  // full-tick polls until the predicted phase reaches the target
  task automatic pump_to(input logic [3:0] target, input logic busy);
    int guard;
    guard = 0;
    while (ctl_phase != target && guard < 20000) begin
      send_poll(mk_poll(4'd15, 1'b0, 1'b0, busy, 1'b0, '0, 1'b0, '0));
      guard++;
    end
    if (ctl_phase != target) report_mismatch("phase walk did not reach its target");
  endtask

  // waits until every poll has answered; registers are only written then
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (awaited_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(input logic [15:0] door, input logic [15:0] timeout,
      input logic [15:0] hold, input logic [2:0] attempts, input logic [55:0] pin);
    wait_idle();
    write_reg(CFG_DOOR_TICKS, 56'(door));
    write_reg(CFG_PIN_TIMEOUT, 56'(timeout));
    write_reg(CFG_ALARM_HOLD, 56'(hold));
    write_reg(CFG_MAX_ATTEMPTS, 56'(attempts));
    write_reg(CFG_EXPECTED_PIN, pin);
  endtask

  // from idle with hello pending: hello, hall, then close outer while the link is busy
  task automatic enter_pin_phase();
    quiet(4'd0);
    send_poll(mk_poll(4'd0, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
    pump_to(PH_PIN, 1'b1);
  endtask

  // from the alarm: thief, hold, then a yes to the reset question restarts
  task automatic clear_alarm();
    pump_to(PH_RESET_Q, 1'b0);
    send_reply(REPLY_YES);
  endtask

  // default registers, full walk from hello to close both
  task automatic test_reset_walk();
    send_poll(mk_poll(4'd0, 1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b0, '0));
    // all fields at their top value while busy: hello held back, pulses latched
    send_poll(mk_poll(4'd15, 1'b1, 1'b1, 1'b1, 1'b1, '1, 1'b1, '1));
    quiet(4'd0);
    quiet(4'd0);
    pump_to(PH_PIN, 1'b1);
    send_pin(1'b1, EXPECTED_PIN_RST);
    send_pin(1'b0, EXPECTED_PIN_RST);
    send_pin(1'b0, EXPECTED_PIN_RST);
    pump_to(PH_WAIT_EXIT, 1'b0);
    // exit was latched long ago, so the question comes right away
    quiet(4'd0);
    send_reply(REPLY_YES);
    send_poll(mk_poll(4'd0, 1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b0, '0));
    quiet(4'd0);
    pump_to(PH_IDLE, 1'b0);
  endtask

  // wrong pins, busy link during entry, attempt limit lowered mid-way,
  // and reset question replies that do not decode
  task automatic test_pin_retry();
    write_all(16'd1, 16'hFFFF, 16'd1, 3'd7, '1);
    enter_pin_phase();
    send_pin(1'b0, '0);
    send_pin(1'b0, '0);
    send_pin(1'b1, '0);
    send_pin(1'b0, '0);
    send_pin(1'b0, '0);
    wait_idle();
    write_reg(CFG_MAX_ATTEMPTS, 56'd1);
    quiet(4'd0);
    send_poll(mk_poll(4'd0, 1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b0, '0));
    quiet(4'd0);
    quiet(4'd1);
    // no is only an answer to the exit question
    send_reply({REPLY_NO, 8'h21});
    quiet(4'd0);
    quiet(4'd0);
    send_reply(24'h59657A);
    send_reply(REPLY_YES);
  endtask

  // all-zero pin accepted, close inner withheld while busy, no to exit question
  task automatic test_exit_no();
    write_all(16'd1, 16'hFFFF, 16'd1, 3'd7, '0);
    enter_pin_phase();
    send_pin(1'b0, '0);
    send_pin(1'b0, '0);
    send_poll(mk_poll(4'd15, 1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b0, '0));
    send_poll(mk_poll(4'd0, 1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0));
    send_reply({REPLY_NO, 8'h00});
    clear_alarm();
  endtask

  // pin entry timeout, then an attempt limit of zero
  task automatic test_timeout_limit();
    write_all(16'd1, 16'd1, 16'd1, 3'd7, EXPECTED_PIN_RST);
    enter_pin_phase();
    quiet(4'd1);
    clear_alarm();
    write_all(16'd1, 16'hFFFF, 16'd1, 3'd0, EXPECTED_PIN_RST);
    enter_pin_phase();
    quiet(4'd0);
    clear_alarm();
  endtask

  // poll shaped by the predicted phase so most polls move the sequence on
  function automatic airlock_poll_t random_poll();
    airlock_poll_t p;
    int            pick;
    logic [55:0]   noise_pin;
    noise_pin   = 56'({$urandom(), $urandom()});
    p.ticks     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 3));
    p.hall      = ($urandom_range(0, (ctl_phase == PH_IDLE) ? 1 : 9) == 0);
    p.exit_req  = ($urandom_range(0, (ctl_phase == PH_WAIT_EXIT) ? 2 : 11) == 0);
    p.busy      = ($urandom_range(0, 3) == 0);
    p.pin_rdy   = ($urandom_range(0, (ctl_phase == PH_PIN) ? 1 : 15) == 0);
    p.reply_rdy = (ctl_phase == PH_EXIT_Q || ctl_phase == PH_RESET_Q) ?
                  ($urandom_range(0, 4) < 2) : ($urandom_range(0, 15) == 0);
    pick = $urandom_range(0, 9);
    if (pick < 6) p.pin = expected_pin_reg;
    else if (pick < 8) p.pin = expected_pin_reg ^ (56'd1 << $urandom_range(0, 55));
    else p.pin = noise_pin;
    pick = $urandom_range(0, 9);
    if (pick < 5) p.reply = REPLY_YES;
    else if (pick < 7) p.reply = {REPLY_NO, 8'($urandom_range(0, 255))};
    else if (pick < 8) p.reply = {REPLY_YES[23:8], 8'($urandom_range(0, 255))};
    else p.reply = 24'($urandom());
    return p;
  endfunction

  // rounds of random polls under fresh settings; the last round runs with no idling
  task automatic test_random_traffic();
    for (int round = 0; round < 4; round++) begin
      write_all(16'($urandom_range(1, 24)), 16'($urandom_range(5, 400)),
                16'($urandom_range(1, 60)), 3'($urandom_range(1, 7)),
                56'({$urandom(), $urandom()}));
      idling_on = (round < 3);
      repeat (75) send_poll(random_poll());
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.tick_count  = '0;
    in_ch.hall_pulse  = 1'b0;
    in_ch.exit_pulse  = 1'b0;
    in_ch.serial_busy = 1'b0;
    in_ch.pin_ready   = 1'b0;
    in_ch.pin_text    = '0;
    in_ch.reply_ready = 1'b0;
    in_ch.reply_text  = '0;
    out_ch.ready      = 1'b0;
    mismatch_count    = 0;
    ready_stall_left  = 0;
    idling_on         = 1'b1;
    door_ticks_reg    = DOOR_TICKS_RST;
    pin_timeout_reg   = PIN_TIMEOUT_RST;
    alarm_hold_reg    = ALARM_HOLD_RST;
    max_attempts_reg  = MAX_ATTEMPTS_RST;
    expected_pin_reg  = EXPECTED_PIN_RST;
    restart_controller();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_walk();
    test_pin_retry();
    test_exit_no();
    test_timeout_limit();
    test_random_traffic();

    // drain the last results, then allow for the pipeline depth
    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ airlock_door_access_fsm.f @@
+incdir+hw/rtl
hw/rtl/adafsm_pkg.sv
hw/rtl/adafsm_if.sv
hw/rtl/airlock_door_access_fsm.sv
tb/airlock_door_access_fsm_tb.sv
